[hdl/tkd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkd_pkg
// types and constants shared by the terminal key escape decoder
// ----------------------------------------------------------------------------
package tkd_pkg;

   // parser state codes
   typedef enum logic [2:0] {
      MODE_IDLE = 3'd0,
      MODE_ESC  = 3'd1,
      MODE_SS3  = 3'd2,
      MODE_NUM  = 3'd3,
      MODE_MOD  = 3'd4
   } mode_type;

   // received byte codes
   localparam logic [7:0] CHR_ESC    = 8'h1B;
   localparam logic [7:0] CHR_LBRACK = 8'h5B;
   localparam logic [7:0] CHR_SS3    = 8'h4F;
   localparam logic [7:0] CHR_TILDE  = 8'h7E;
   localparam logic [7:0] CHR_SEMI   = 8'h3B;
   localparam logic [7:0] CHR_ZERO   = 8'h30;
   localparam logic [7:0] CHR_NINE   = 8'h39;
   localparam logic [7:0] CHR_A      = 8'h41;
   localparam logic [7:0] CHR_B      = 8'h42;
   localparam logic [7:0] CHR_C      = 8'h43;
   localparam logic [7:0] CHR_D      = 8'h44;
   localparam logic [7:0] CHR_F      = 8'h46;
   localparam logic [7:0] CHR_H      = 8'h48;
   localparam logic [7:0] CHR_P      = 8'h50;
   localparam logic [7:0] CHR_Q      = 8'h51;
   localparam logic [7:0] CHR_R      = 8'h52;
   localparam logic [7:0] CHR_S      = 8'h53;

   // named key indexes
   localparam logic [7:0] KEY_ESC   = 8'd0;
   localparam logic [7:0] KEY_UP    = 8'd1;
   localparam logic [7:0] KEY_DOWN  = 8'd2;
   localparam logic [7:0] KEY_RIGHT = 8'd3;
   localparam logic [7:0] KEY_LEFT  = 8'd4;
   localparam logic [7:0] KEY_HOME  = 8'd5;
   localparam logic [7:0] KEY_END   = 8'd6;
   localparam logic [7:0] KEY_INS   = 8'd7;
   localparam logic [7:0] KEY_DEL   = 8'd8;
   localparam logic [7:0] KEY_PGUP  = 8'd9;
   localparam logic [7:0] KEY_PGDN  = 8'd10;
   localparam logic [7:0] KEY_F1    = 8'd11;
   localparam logic [7:0] KEY_F2    = 8'd12;
   localparam logic [7:0] KEY_F3    = 8'd13;
   localparam logic [7:0] KEY_F4    = 8'd14;
   localparam logic [7:0] KEY_F5    = 8'd15;
   localparam logic [7:0] KEY_F6    = 8'd16;
   localparam logic [7:0] KEY_F7    = 8'd17;
   localparam logic [7:0] KEY_F8    = 8'd18;
   localparam logic [7:0] KEY_F9    = 8'd19;
   localparam logic [7:0] KEY_F10   = 8'd20;
   localparam logic [7:0] KEY_F11   = 8'd21;
   localparam logic [7:0] KEY_F12   = 8'd22;

   // csi modifier value meaning shift
   localparam logic [7:0] MOD_SHIFT = 8'd2;

   // results held in the output buffer
   localparam logic [1:0] RSP_DEPTH = 2'd2;

   // one result item
   typedef struct packed {
      logic       named;
      logic [7:0] code;
      logic       shifted;
      logic       last;
   } rsp_type;

   // results caused by the item in the input register
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } parse_out_type;

endpackage

[hdl/tkd_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkd_parser
// escape sequence state machine; while advance is high, decodes one registered item per cycle
// ----------------------------------------------------------------------------
module tkd_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,    // item consumed this cycle
   input  logic                  item_gap,
   input  logic [7:0]            item_byte,
   output tkd_pkg::parse_out_type parse_out
);
   import tkd_pkg::*;

   mode_type   mode_ff, mode_in;
   logic [7:0] num_ff, num_in;
   logic       have_ff, have_in;
   logic [7:0] mod_ff, mod_in;

   logic       is_digit;
   logic [3:0] digit_val;
   logic       fin_hit;
   logic [7:0] fin_code;
   logic       tilde_hit;
   logic [7:0] tilde_code;

   // acc * 10 + digit, held at 255 once it passes
   function automatic logic [7:0] sat_digit(input logic [7:0] acc, input logic [3:0] d);
      logic [11:0] v;
      v = ({4'd0, acc} * 12'd10) + {8'd0, d};
      return (v > 12'd255) ? 8'd255 : v[7:0];
   endfunction

   function automatic rsp_type mk_rsp(input logic named, input logic [7:0] code,
                                      input logic shifted);
      rsp_type r;
      r.named   = named;
      r.code    = code;
      r.shifted = shifted;
      r.last    = 1'b0;
      return r;
   endfunction

   assign is_digit  = (item_byte >= CHR_ZERO) && (item_byte <= CHR_NINE);
   assign digit_val = item_byte[3:0];

   // number before a tilde final
   always_comb begin
      tilde_hit  = 1'b1;
      tilde_code = KEY_ESC;
      unique case (num_ff)
         8'd2:    tilde_code = KEY_INS;
         8'd3:    tilde_code = KEY_DEL;
         8'd5:    tilde_code = KEY_PGUP;
         8'd6:    tilde_code = KEY_PGDN;
         8'd15:   tilde_code = KEY_F5;
         8'd17:   tilde_code = KEY_F6;
         8'd18:   tilde_code = KEY_F7;
         8'd19:   tilde_code = KEY_F8;
         8'd20:   tilde_code = KEY_F9;
         8'd21:   tilde_code = KEY_F10;
         8'd23:   tilde_code = KEY_F11;
         8'd24:   tilde_code = KEY_F12;
         default: tilde_hit  = 1'b0;
      endcase
   end

   // csi final byte
   always_comb begin
      fin_hit  = 1'b1;
      fin_code = KEY_ESC;
      unique case (item_byte)
         CHR_A:     fin_code = KEY_UP;
         CHR_B:     fin_code = KEY_DOWN;
         CHR_C:     fin_code = KEY_RIGHT;
         CHR_D:     fin_code = KEY_LEFT;
         CHR_H:     fin_code = KEY_HOME;
         CHR_F:     fin_code = KEY_END;
         CHR_P:     fin_code = KEY_F1;
         CHR_Q:     fin_code = KEY_F2;
         CHR_R:     fin_code = KEY_F3;
         CHR_S:     fin_code = KEY_F4;
         CHR_TILDE: begin
            fin_hit  = have_ff && tilde_hit;
            fin_code = tilde_code;
         end
         default:   fin_hit = 1'b0;
      endcase
   end

   always_comb begin
      mode_in = mode_ff;
      num_in  = num_ff;
      have_in = have_ff;
      mod_in  = mod_ff;
      parse_out.count  = 2'd0;
      parse_out.first  = mk_rsp(1'b1, KEY_ESC, 1'b0);
      parse_out.second = mk_rsp(1'b0, item_byte, 1'b0);

      unique case (mode_ff)
         MODE_ESC: begin
            if (item_gap) begin
               mode_in         = MODE_IDLE;
               parse_out.count = 2'd1;
            end else if (item_byte == CHR_LBRACK) begin
               mode_in = MODE_NUM;
               num_in  = 8'd0;
               have_in = 1'b0;
               mod_in  = 8'd0;
            end else if (item_byte == CHR_SS3) begin
               mode_in = MODE_SS3;
            end else if (item_byte == CHR_ESC) begin
               // escape key, then a fresh sequence starts
               mode_in         = MODE_ESC;
               parse_out.count = 2'd1;
            end else begin
               mode_in         = MODE_IDLE;
               parse_out.count = 2'd2;
            end
         end
         MODE_SS3: begin
            mode_in = MODE_IDLE;
            if (!item_gap && item_byte >= CHR_P && item_byte <= CHR_S) begin
               parse_out.count = 2'd1;
               parse_out.first = mk_rsp(1'b1, KEY_F1 + (item_byte - CHR_P), 1'b0);
            end
         end
         MODE_NUM, MODE_MOD: begin
            if (item_gap) begin
               mode_in         = MODE_IDLE;
               parse_out.count = 2'd1;
            end else if (is_digit) begin
               if (mode_ff == MODE_NUM) begin
                  num_in  = sat_digit(num_ff, digit_val);
                  have_in = 1'b1;
               end else begin
                  mod_in = sat_digit(mod_ff, digit_val);
               end
            end else if (item_byte == CHR_SEMI && mode_ff == MODE_NUM) begin
               mod_in  = 8'd0;
               mode_in = MODE_MOD;
            end else begin
               mode_in         = MODE_IDLE;
               parse_out.count = fin_hit ? 2'd1 : 2'd0;
               parse_out.first = mk_rsp(1'b1, fin_code, mod_ff == MOD_SHIFT);
            end
         end
         default: begin
            mode_in = MODE_IDLE;
            if (!item_gap) begin
               if (item_byte == CHR_ESC) begin
                  mode_in = MODE_ESC;
               end else begin
                  parse_out.count = 2'd1;
                  parse_out.first = mk_rsp(1'b0, item_byte, 1'b0);
               end
            end
         end
      endcase

      // mark the final result of the run
      parse_out.first.last  = (parse_out.count == 2'd1);
      parse_out.second.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         num_ff  <= 8'd0;
         have_ff <= 1'b0;
         mod_ff  <= 8'd0;
      end else if (advance) begin
         mode_ff <= mode_in;
         num_ff  <= num_in;
         have_ff <= have_in;
         mod_ff  <= mod_in;
      end
   end

`ifndef SYNTH
   a_two_starts_with_esc: assert property (@(posedge clock) disable iff (reset)
      parse_out.count == 2'd2 |-> parse_out.first.named && parse_out.first.code == KEY_ESC)
      else $error("two results must start with the escape key");
   a_two_only_after_esc: assert property (@(posedge clock) disable iff (reset)
      parse_out.count == 2'd2 |-> mode_ff == MODE_ESC && !item_gap)
      else $error("two results outside the after-escape state");
   a_have_tracks_num: assert property (@(posedge clock) disable iff (reset)
      !have_ff |-> num_ff == 8'd0)
      else $error("parameter value without a digit seen");
`endif
endmodule

[hdl/tkd_rsp_buffer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tkd_rsp_buffer
// two-entry result buffer feeding the result channel
// ----------------------------------------------------------------------------
module tkd_rsp_buffer (
   input  logic             clock,
   input  logic             reset,
   input  logic [1:0]       push_cnt,
   input  tkd_pkg::rsp_type push_first,
   input  tkd_pkg::rsp_type push_second,
   output logic [1:0]       free_cnt,   // slots free after this cycle's pop
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [15:0]      rsp_tdata,  // [7:0] key_code, [8] shifted, [15:9] zero
   output logic             rsp_tuser,  // [0] is_named_key
   output logic             rsp_tlast   // last_of_run
);
   import tkd_pkg::*;

   rsp_type    q0_ff, q0_in;
   rsp_type    q1_ff, q1_in;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] cnt_rem;
   logic       pop;

   assign pop      = rsp_tvalid && rsp_tready;
   assign cnt_rem  = cnt_ff - {1'b0, pop};
   assign free_cnt = RSP_DEPTH - cnt_rem;

   always_comb begin
      cnt_in = cnt_rem + push_cnt;
      q1_in  = q1_ff;
      if (cnt_rem == 2'd0) begin
         q0_in = push_first;
         q1_in = push_second;
      end else begin
         q0_in = pop ? q1_ff : q0_ff;
         if (cnt_rem == 2'd1) begin
            q1_in = push_first;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
   end

   assign rsp_tvalid = (cnt_ff != 2'd0);
   assign rsp_tdata  = {7'd0, q0_ff.shifted, q0_ff.code};
   assign rsp_tuser  = q0_ff.named;
   assign rsp_tlast  = q0_ff.last;

`ifndef SYNTH
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= RSP_DEPTH)
      else $error("result buffer count out of range");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push_cnt <= free_cnt)
      else $error("result buffer overflow");
   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      pop && push_cnt == 2'd0 |=> cnt_ff == $past(cnt_ff) - 2'd1)
      else $error("result lost or repeated");
`endif
endmodule

[hdl/terminal_key_escape_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_key_escape_decoder_unit
// turns terminal bytes and gap events into plain bytes and named key codes
// ----------------------------------------------------------------------------
//  channel  dir  group                      payload
//  req      in   req_tvalid/tready/tdata    tdata[7:0] data_byte, tuser is_gap
//  rsp      out  rsp_tvalid/tready/tdata    tdata[7:0] key_code, tdata[8] shifted,
//                                           tuser is_named_key, tlast last_of_run
//
//  one item per cycle while each item gives at most one result and rsp_tready is high;
//  the single result port moves one result per cycle while rsp_tready is high, so an
//  item that gives two results (escape then the following byte) waits in the input
//  register only when the two-entry buffer cannot take both after this cycle's pop
//  results are pushed into the result buffer when their item leaves the input register
//  synchronous reset returns the parser to idle and empties both registers
//  a stalled rsp side fills the buffer, then req_tready drops
// ----------------------------------------------------------------------------
module terminal_key_escape_decoder_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] is_gap
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [7:0] key_code, [8] shifted, [15:9] zero
   output logic        rsp_tuser,   // [0] is_named_key
   output logic        rsp_tlast    // last_of_run
);
   import tkd_pkg::*;

   // input register
   logic          in_valid_ff;
   logic          in_gap_ff;
   logic [7:0]    in_byte_ff;

   parse_out_type parse_out;
   logic [1:0]    free_cnt;
   logic          consume;
   logic          req_xfer;

   // the held item goes once all its results fit in the buffer
   assign consume    = in_valid_ff && (parse_out.count <= free_cnt);
   assign req_tready = !in_valid_ff || consume;
   assign req_xfer   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_gap_ff  <= req_tuser;
         in_byte_ff <= req_tdata;
      end
   end

   tkd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (consume),
      .item_gap  (in_gap_ff),
      .item_byte (in_byte_ff),
      .parse_out (parse_out)
   );

   tkd_rsp_buffer u_rsp_buffer (
      .clock       (clock),
      .reset       (reset),
      .push_cnt    (consume ? parse_out.count : 2'd0),
      .push_first  (parse_out.first),
      .push_second (parse_out.second),
      .free_cnt    (free_cnt),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

`ifndef SYNTH
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && !in_valid_ff)
      else $error("registers not empty after reset");
   a_stall_holds_item: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !consume |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_gap_ff))
      else $error("held item changed before it was consumed");
   a_free_drain: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("empty input register refused a transfer");
`endif
endmodule

[bench/terminal_key_escape_decoder_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// terminal_key_escape_decoder_unit_tb
// self-checking bench for the terminal key escape decoder: a directed table of
// plain bytes, escape, ss3 and csi sequences, then random bursts of well-formed,
// truncated and garbled sequences, scored against typed keys or a key decoding model
// ----------------------------------------------------------------------------
module terminal_key_escape_decoder_unit_tb;
   import tkd_pkg::*;

   localparam int          RANDOM_ITEMS = 1700;
   localparam int          CYCLE_LIMIT  = 500000;
   // cycles to let pass after the last key
   localparam int          DRAIN_CYCLES = 10;

   // one stimulus row; the keys are used only when keys_typed is set
   typedef struct packed {
      logic       gap;
      logic [7:0] data;
      logic       keys_typed;
      logic [1:0] key_count;
      rsp_type    key0;
      rsp_type    key1;
   } key_row_type;

   localparam rsp_type NO_KEY       = '0;
   localparam rsp_type ESC_KEY_MID  = '{1'b1, KEY_ESC, 1'b0, 1'b0};
   localparam rsp_type ESC_KEY_LAST = '{1'b1, KEY_ESC, 1'b0, 1'b1};

   // directed table: rows with keys_typed clear are scored by the model below
   localparam int DIRECTED_COUNT = 27;
   localparam key_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      // gap while idle gives nothing
      '{1'b1, 8'hA5, 1'b1, 2'd0, NO_KEY, NO_KEY},
      // lowest and highest plain bytes pass straight through
      '{1'b0, 8'h00, 1'b1, 2'd1, '{1'b0, 8'h00, 1'b0, 1'b1}, NO_KEY},
      '{1'b0, 8'hFF, 1'b1, 2'd1, '{1'b0, 8'hFF, 1'b0, 1'b1}, NO_KEY},
      // lone escape closed by a gap
      '{1'b0, CHR_ESC, 1'b1, 2'd0, NO_KEY, NO_KEY},
      '{1'b1, 8'h00, 1'b1, 2'd1, ESC_KEY_LAST, NO_KEY},
      // ss3 function key
      '{1'b0, CHR_ESC, 1'b0, 2'd0, NO_KEY, NO_KEY},
      '{1'b0, CHR_SS3, 1'b0, 2'd0, NO_KEY, NO_KEY},
      '{1'b0, CHR_S, 1'b0, 2'd0, NO_KEY, NO_KEY},
      // gap after ss3 is swallowed
      '{1'b0, CHR_ESC, 1'b0, 2'd0, NO_KEY, NO_KEY},
      '{1'b0, CHR_SS3, 1'b0, 2'd0, NO_KEY, NO_KEY},
      '{1'b1, 8'hFF, 1'b0, 2'd0, NO_KEY, NO_KEY},
      // escape then escape restarts, then escape then a byte gives two keys
      '{1'b0, CHR_ESC, 1'b1, 2'd0, NO_KEY, NO_KEY},
      '{1'b0, CHR_ESC, 1'b1, 2'd1, ESC_KEY_LAST, NO_KEY},
      '{1'b0, 8'hFF, 1'b1, 2'd2, ESC_KEY_MID, '{1'b0, 8'hFF, 1'b0, 1'b1}},
      // truncated csi gives escape
      '{1'b0, CHR_ESC, 1'b0, 2'd0, NO_KEY, NO_KEY},
      '{1'b0, CHR_LBRACK, 1'b0, 2'd0, NO_KEY, NO_KEY},
      '{1'b0, CHR_ZERO + 8'd5, 1'b0, 2'd0, NO_KEY, NO_KEY},
      '{1'b1, 8'h00, 1'b0, 2'd0, NO_KEY, NO_KEY},
      // shifted insert
      '{1'b0, CHR_ESC, 1'b0, 2'd0, NO_KEY, NO_KEY},
      '{1'b0, CHR_LBRACK, 1'b0, 2'd0, NO_KEY, NO_KEY},
      '{1'b0, CHR_ZERO + 8'd2, 1'b0, 2'd0, NO_KEY, NO_KEY},
      '{1'b0, CHR_SEMI, 1'b0, 2'd0, NO_KEY, NO_KEY},
      '{1'b0, CHR_ZERO + 8'd2, 1'b0, 2'd0, NO_KEY, NO_KEY},
      '{1'b0, CHR_TILDE, 1'b0, 2'd0, NO_KEY, NO_KEY},
      // tilde without a parameter is swallowed
      '{1'b0, CHR_ESC, 1'b0, 2'd0, NO_KEY, NO_KEY},
      '{1'b0, CHR_LBRACK, 1'b0, 2'd0, NO_KEY, NO_KEY},
      '{1'b0, CHR_TILDE, 1'b0, 2'd0, NO_KEY, NO_KEY}
   };

   // parameters that select a key with a tilde, and the usual csi finals
   localparam int unsigned TILDE_NUMBERS [12] = '{2, 3, 5, 6, 15, 17, 18, 19, 20, 21, 23, 24};
   localparam logic [7:0] CSI_FINALS [11] = '{CHR_A, CHR_B, CHR_C, CHR_D, CHR_H, CHR_F,
                                             CHR_P, CHR_Q, CHR_R, CHR_S, CHR_TILDE};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] data_byte
   logic        req_tuser;    // [0] is_gap
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;    // [7:0] key_code, [8] shifted, [15:9] zero
   logic        rsp_tuser;    // [0] is_named_key
   logic        rsp_tlast;    // last_of_run

   // row currently offered on the req side
   key_row_type current_row;

   // model state
   mode_type    scan_mode;
   logic [7:0]  param_value;
   logic        param_seen;
   logic [7:0]  modifier_value;

   rsp_type     decoded_keys[$];     // keys caused by the item just accepted
   rsp_type     expected_keys[$];    // keys still owed by the block
   key_row_type burst_rows[$];       // random rows waiting to be sent

   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned fail_count  = 0;
   int unsigned cycle_count = 0;

   terminal_key_escape_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // ------------------------------------------------------------------------
   // key decoding model
   // ------------------------------------------------------------------------

   function automatic logic [7:0] add_digit(input logic [7:0] acc, input logic [7:0] ch);
      int unsigned sum;
      sum = acc * 10 + (ch - CHR_ZERO);
      return (sum > 255) ? 8'd255 : sum[7:0];
   endfunction

   // key index for a csi tilde parameter, -1 when the number is unknown
   function automatic int tilde_key(input logic [7:0] num);
      case (num)
         8'd2:    return KEY_INS;
         8'd3:    return KEY_DEL;
         8'd5:    return KEY_PGUP;
         8'd6:    return KEY_PGDN;
         8'd15:   return KEY_F5;
         8'd17:   return KEY_F6;
         8'd18:   return KEY_F7;
         8'd19:   return KEY_F8;
         8'd20:   return KEY_F9;
         8'd21:   return KEY_F10;
         8'd23:   return KEY_F11;
         8'd24:   return KEY_F12;
         default: return -1;
      endcase
   endfunction

   task automatic add_key(input logic named, input logic [7:0] code, input logic shifted);
      decoded_keys.push_back(rsp_type'{named, code, shifted, 1'b0});
   endtask

   // byte seen while idle: escape opens a sequence, anything else is plain
   task automatic take_idle_byte(input logic [7:0] b);
      if (b == CHR_ESC) begin
         scan_mode = MODE_ESC;
      end else begin
         scan_mode = MODE_IDLE;
         add_key(1'b0, b, 1'b0);
      end
   endtask

   // byte that closes a csi sequence
   task automatic take_csi_final(input logic [7:0] b);
      int key;
      key = -1;
      scan_mode = MODE_IDLE;
      case (b)
         CHR_A:     key = KEY_UP;
         CHR_B:     key = KEY_DOWN;
         CHR_C:     key = KEY_RIGHT;
         CHR_D:     key = KEY_LEFT;
         CHR_H:     key = KEY_HOME;
         CHR_F:     key = KEY_END;
         CHR_P:     key = KEY_F1;
         CHR_Q:     key = KEY_F2;
         CHR_R:     key = KEY_F3;
         CHR_S:     key = KEY_F4;
         CHR_TILDE: if (param_seen) key = tilde_key(param_value);
         default:   key = -1;
      endcase
      if (key >= 0) add_key(1'b1, key[7:0], modifier_value == MOD_SHIFT);
   endtask

   // one accepted item into decoded_keys, last flag on the final key
   task automatic decode_terminal_item(input logic gap, input logic [7:0] b);
      logic    is_digit;
      rsp_type tail;
      is_digit = (b >= CHR_ZERO) && (b <= CHR_NINE);
      decoded_keys.delete();
      case (scan_mode)
         MODE_ESC: begin
            if (gap) begin
               scan_mode = MODE_IDLE;
               add_key(1'b1, KEY_ESC, 1'b0);
            end else if (b == CHR_LBRACK) begin
               scan_mode      = MODE_NUM;
               param_value    = 8'd0;
               param_seen     = 1'b0;
               modifier_value = 8'd0;
            end else if (b == CHR_SS3) begin
               scan_mode = MODE_SS3;
            end else begin
               // escape is given, then the byte is taken as if idle
               add_key(1'b1, KEY_ESC, 1'b0);
               take_idle_byte(b);
            end
         end
         MODE_SS3: begin
            scan_mode = MODE_IDLE;
            if (!gap && b >= CHR_P && b <= CHR_S) add_key(1'b1, KEY_F1 + (b - CHR_P), 1'b0);
         end
         MODE_NUM: begin
            if (gap) begin
               scan_mode = MODE_IDLE;
               add_key(1'b1, KEY_ESC, 1'b0);
            end else if (is_digit) begin
               param_value = add_digit(param_value, b);
               param_seen  = 1'b1;
            end else if (b == CHR_SEMI) begin
               modifier_value = 8'd0;
               scan_mode      = MODE_MOD;
            end else begin
               take_csi_final(b);
            end
         end
         MODE_MOD: begin
            if (gap) begin
               scan_mode = MODE_IDLE;
               add_key(1'b1, KEY_ESC, 1'b0);
            end else if (is_digit) begin
               modifier_value = add_digit(modifier_value, b);
            end else begin
               // a second semicolon lands here and swallows the sequence
               take_csi_final(b);
            end
         end
         default: begin
            scan_mode = MODE_IDLE;
            if (!gap) take_idle_byte(b);
         end
      endcase
      if (decoded_keys.size() > 0) begin
         tail = decoded_keys.pop_back();
         tail.last = 1'b1;
         decoded_keys.push_back(tail);
      end
   endtask

   // ------------------------------------------------------------------------
   // scoreboard
   // ------------------------------------------------------------------------

   // req transfer: run the model and queue what the block owes
   always @(posedge clock) begin
      if (reset) begin
         scan_mode      = MODE_IDLE;
         param_value    = 8'd0;
         param_seen     = 1'b0;
         modifier_value = 8'd0;
      end else if (req_tvalid && req_tready) begin
         decode_terminal_item(current_row.gap, current_row.data);
         if (current_row.keys_typed) begin
            // hand-written keys take the place of the model's for this row
            if (current_row.key_count >= 2'd1) expected_keys.push_back(current_row.key0);
            if (current_row.key_count == 2'd2) expected_keys.push_back(current_row.key1);
         end else begin
            foreach (decoded_keys[i]) expected_keys.push_back(decoded_keys[i]);
         end
      end
   end

   // rsp transfer: compare with the oldest key owed
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_keys.size() == 0) begin
            $error("unexpected key: is_named_key %0d key_code %0d", rsp_tuser, rsp_tdata[7:0]);
            fail_count++;
         end else begin
            want = expected_keys.pop_front();
            if (rsp_tuser !== want.named) begin
               $error("is_named_key mismatch: expected %0d, got %0d", want.named, rsp_tuser);
               fail_count++;
            end
            if (rsp_tdata[7:0] !== want.code) begin
               $error("key_code mismatch: expected %0d, got %0d", want.code, rsp_tdata[7:0]);
               fail_count++;
            end
            if (rsp_tdata[8] !== want.shifted) begin
               $error("shifted mismatch: expected %0d, got %0d", want.shifted, rsp_tdata[8]);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("last_of_run mismatch: expected %0d, got %0d", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // receiver stalls at random, redrawn every cycle
   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // ------------------------------------------------------------------------
   // stimulus
   // ------------------------------------------------------------------------

   // offer one row at a falling edge, return at the falling edge after its transfer
   task automatic send_row(input key_row_type row);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      current_row <= row;
      req_tdata   <= row.data;
      req_tuser   <= row.gap;
      req_tvalid  <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic queue_byte(input logic [7:0] b);
      burst_rows.push_back(key_row_type'{1'b0, b, 1'b0, 2'd0, NO_KEY, NO_KEY});
   endtask

   // data bits of a gap are don't-care, so they toggle too
   task automatic queue_gap();
      burst_rows.push_back(key_row_type'{1'b1, 8'($urandom_range(255)), 1'b0, 2'd0,
                                         NO_KEY, NO_KEY});
   endtask

   task automatic queue_decimal(input int unsigned value);
      int unsigned scale;
      scale = 1;
      while (scale * 10 <= value) scale *= 10;
      while (scale > 0) begin
         queue_byte(CHR_ZERO + 8'((value / scale) % 10));
         scale /= 10;
      end
   endtask

   // one random burst: mostly well-formed sequences, some noise and breakage
   task automatic build_random_burst();
      int unsigned kind;
      int unsigned pick;
      int unsigned count;
      kind = $urandom_range(99);
      if (kind < 40) begin
         // csi: optional parameter, optional modifier, final
         queue_byte(CHR_ESC);
         queue_byte(CHR_LBRACK);
         pick = $urandom_range(9);
         if (pick < 5)      queue_decimal(TILDE_NUMBERS[$urandom_range(11)]);
         else if (pick < 7) queue_decimal($urandom_range(99));
         else if (pick < 9) queue_decimal($urandom_range(99999));   // saturates
         if ($urandom_range(9) >= 4) begin
            queue_byte(CHR_SEMI);
            pick = $urandom_range(9);
            if (pick < 5)      queue_decimal(2);
            else if (pick < 7) queue_decimal($urandom_range(9));
            else if (pick < 9) queue_decimal($urandom_range(9999));
            if ($urandom_range(19) == 0) queue_byte(CHR_SEMI);
         end
         pick = $urandom_range(19);
         if (pick < 15)      queue_byte(CSI_FINALS[$urandom_range(10)]);
         else if (pick < 17) queue_byte(8'($urandom_range(255)));
         else                queue_gap();
      end else if (kind < 55) begin
         // ss3 function keys, with the odd wrong byte or gap
         queue_byte(CHR_ESC);
         queue_byte(CHR_SS3);
         pick = $urandom_range(9);
         if (pick < 7)      queue_byte(CHR_P + 8'($urandom_range(3)));
         else if (pick < 9) queue_byte(8'($urandom_range(255)));
         else               queue_gap();
      end else if (kind < 65) begin
         // escape followed by a gap, another escape or any byte
         queue_byte(CHR_ESC);
         pick = $urandom_range(3);
         if (pick == 0)      queue_gap();
         else if (pick == 1) queue_byte(CHR_ESC);
         else                queue_byte(8'($urandom_range(255)));
      end else if (kind < 85) begin
         // plain bytes and idle gaps
         count = $urandom_range(4, 1);
         repeat (count) begin
            if ($urandom_range(4) == 0) queue_gap();
            else                        queue_byte(8'($urandom_range(255)));
         end
      end else begin
         // noise built from the bytes that steer the parser
         count = $urandom_range(6, 1);
         repeat (count) begin
            case ($urandom_range(6))
               0:       queue_byte(CHR_ESC);
               1:       queue_byte(CHR_LBRACK);
               2:       queue_byte(CHR_SS3);
               3:       queue_byte(CHR_SEMI);
               4:       queue_byte(CHR_TILDE);
               5:       queue_byte(CHR_ZERO + 8'($urandom_range(9)));
               default: queue_gap();
            endcase
         end
      end
   endtask

   initial begin
      int unsigned sent;
      req_tvalid     = 1'b0;
      req_tdata      = 8'd0;
      req_tuser      = 1'b0;
      rsp_tready     = 1'b0;
      current_row    = '0;
      reset          = 1'b1;
      send_idle_pct  = 15;
      recv_stall_pct = 84;

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table
      foreach (DIRECTED_ROWS[i]) send_row(DIRECTED_ROWS[i]);

      // random bursts in three idling phases
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
         end else if (sent >= RANDOM_ITEMS / 3) begin
            send_idle_pct  = 84;
            recv_stall_pct = 15;
         end
         build_random_burst();
         while (burst_rows.size() > 0) begin
            send_row(burst_rows.pop_front());
            sent++;
         end
      end
      req_tvalid <= 1'b0;

      // let every owed key arrive, then a short quiet spell
      while (expected_keys.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
